// File: rtl/core/pfde_pkg.sv
`timescale 1ns / 1ps

package pfde_pkg;

  localparam int GridSide   = 5;
  localparam int GridCells  = 25;
  localparam int AlphaCount = 26;
  localparam int CellW      = 5;
  localparam int LetterW    = 5;
  localparam int ByteW      = 8;
  localparam int AsciiW     = 7;

  typedef logic [CellW-1:0]   cell_t;
  typedef logic [LetterW-1:0] letter_t;
  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [AsciiW-1:0]  ascii_t;
  typedef logic [2:0]         coord_t;

  localparam byte_t   PadByte    = 8'h78;  // 'x'
  localparam byte_t   SpaceByte  = 8'h20;
  localparam byte_t   FirstByte  = 8'h61;  // 'a'
  localparam byte_t   LastByte   = 8'h7a;  // 'z'
  localparam ascii_t  FirstAscii = 7'h61;
  localparam letter_t SkipLetter = 5'd9;   // 'j'
  localparam letter_t LastLetter = 5'd25;
  localparam cell_t   LastCell   = 5'd24;
  localparam coord_t  LastCoord  = 3'd4;

  typedef enum logic [1:0] {
    REQ_KEY     = 2'd0,
    REQ_KEY_END = 2'd1,
    REQ_TEXT    = 2'd2,
    REQ_MSG_END = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS_B,
    ST_CELLS,
    ST_LET1,
    ST_LET2
  } state_e;

  typedef struct packed {
    logic    grid_we;
    cell_t   grid_waddr;
    letter_t grid_wdata;
    logic    grid_re;
    cell_t   grid_raddr;
    logic    pos_we;
    letter_t pos_waddr;
    cell_t   pos_wdata;
    logic    pos_re;
    letter_t pos_raddr;
  } mem_req_t;

  typedef struct packed {
    logic   load;
    ascii_t first;
    ascii_t second;
  } res_t;

  function automatic logic is_letter(byte_t b);
    return (b >= FirstByte) && (b <= LastByte);
  endfunction

  function automatic letter_t letter_of(byte_t b);
    byte_t diff;
    diff = b - FirstByte;
    return diff[LetterW-1:0];
  endfunction

  function automatic ascii_t letter_ascii(letter_t g);
    return FirstAscii + {2'b00, g};
  endfunction

  function automatic coord_t cell_row(cell_t c);
    coord_t r;
    if (c >= 5'd20)      r = 3'd4;
    else if (c >= 5'd15) r = 3'd3;
    else if (c >= 5'd10) r = 3'd2;
    else if (c >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic cell_t row_base(coord_t r);
    return {r, 2'b00} + {2'b00, r};
  endfunction

  function automatic coord_t cell_col(cell_t c);
    cell_t diff;
    diff = c - row_base(cell_row(c));
    return diff[2:0];
  endfunction

  function automatic cell_t cell_at(coord_t r, coord_t c);
    return row_base(r) + {2'b00, c};
  endfunction

  function automatic coord_t wrap_inc(coord_t x);
    return (x == LastCoord) ? 3'd0 : x + 3'd1;
  endfunction

endpackage

// File: rtl/core/pfde_ram.sv
`timescale 1ns / 1ps

module pfde_ram #(
  parameter int Width = 5,
  parameter int Depth = 25,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pfde_seq.sv
`timescale 1ns / 1ps

module pfde_seq
  import pfde_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic [1:0] req_type_i,
  input  byte_t    char_byte_i,
  input  logic     out_free_i,
  output mem_req_t mem_req_o,
  input  letter_t  grid_rdata_i,
  input  cell_t    pos_rdata_i,
  output res_t     res_o
);

  state_e state_q, state_d;
  cell_t   cells_filled_q, cells_filled_d;
  logic    grid_ready_q, grid_ready_d;
  logic    held_valid_q, held_valid_d;
  logic    prev_valid_q, prev_valid_d;
  logic [AlphaCount-1:0] pos_valid_q, pos_valid_d;
  letter_t fill_idx_q, fill_idx_d;
  logic    a_ok_q, a_ok_d;
  logic    b_ok_q, b_ok_d;

  byte_t   held_q, held_d;
  byte_t   prev_q, prev_d;
  byte_t   op_b_q, op_b_d;
  cell_t   ca_q, ca_d;
  cell_t   t2_q, t2_d;
  letter_t letter1_q, letter1_d;

  logic [31:0] pos_valid_ext;
  logic    place_en;
  letter_t place_idx;
  byte_t   eff;
  byte_t   pair_a, pair_b;
  logic    start_pair;
  cell_t   cb;
  coord_t  r1, c1, r2, c2;
  cell_t   t1, t2;

  assign pos_valid_ext = {{(32 - AlphaCount){1'b0}}, pos_valid_q};

  always_comb begin
    r1 = cell_row(ca_q);
    c1 = cell_col(ca_q);
    cb = b_ok_q ? pos_rdata_i : '0;
    r2 = cell_row(cb);
    c2 = cell_col(cb);
    if (r1 == r2) begin
      t1 = cell_at(r1, wrap_inc(c1));
      t2 = cell_at(r2, wrap_inc(c2));
    end else if (c1 == c2) begin
      t1 = cell_at(wrap_inc(r1), c1);
      t2 = cell_at(wrap_inc(r2), c2);
    end else begin
      t1 = cell_at(r1, c2);
      t2 = cell_at(r2, c1);
    end
  end

  always_comb begin
    state_d        = state_q;
    cells_filled_d = cells_filled_q;
    grid_ready_d   = grid_ready_q;
    held_valid_d   = held_valid_q;
    prev_valid_d   = prev_valid_q;
    pos_valid_d    = pos_valid_q;
    fill_idx_d     = fill_idx_q;
    a_ok_d         = a_ok_q;
    b_ok_d         = b_ok_q;
    held_d         = held_q;
    prev_d         = prev_q;
    op_b_d         = op_b_q;
    ca_d           = ca_q;
    t2_d           = t2_q;
    letter1_d      = letter1_q;
    mem_req_o      = '0;
    res_o          = '0;
    place_en       = 1'b0;
    place_idx      = letter_of(char_byte_i);
    start_pair     = 1'b0;
    pair_a         = held_q;
    pair_b         = PadByte;
    eff = (prev_valid_q && (char_byte_i == prev_q)) ? PadByte : char_byte_i;
    in_stall_o     = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (req_e'(req_type_i))
            REQ_KEY: begin
              place_en = !grid_ready_q && is_letter(char_byte_i);
            end
            REQ_KEY_END: begin
              if (!grid_ready_q) begin
                fill_idx_d = '0;
                state_d    = ST_FILL;
              end
            end
            REQ_TEXT: begin
              if (grid_ready_q && (char_byte_i != SpaceByte)) begin
                prev_d       = eff;
                prev_valid_d = 1'b1;
                if (held_valid_q) begin
                  start_pair = 1'b1;
                  pair_b     = eff;
                end else begin
                  held_d       = eff;
                  held_valid_d = 1'b1;
                end
              end
            end
            REQ_MSG_END: begin
              if (grid_ready_q) begin
                held_d       = '0;
                prev_d       = '0;
                prev_valid_d = 1'b0;
                start_pair   = held_valid_q;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        place_en  = (fill_idx_q != SkipLetter);
        place_idx = fill_idx_q;
        if (fill_idx_q == LastLetter) begin
          grid_ready_d = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          fill_idx_d = fill_idx_q + 5'd1;
        end
      end
      ST_POS_B: begin
        ca_d              = a_ok_q ? pos_rdata_i : '0;
        b_ok_d            = is_letter(op_b_q) && pos_valid_ext[letter_of(op_b_q)];
        mem_req_o.pos_re    = 1'b1;
        mem_req_o.pos_raddr = letter_of(op_b_q);
        state_d           = ST_CELLS;
      end
      ST_CELLS: begin
        mem_req_o.grid_re    = 1'b1;
        mem_req_o.grid_raddr = t1;
        t2_d                 = t2;
        state_d              = ST_LET1;
      end
      ST_LET1: begin
        letter1_d            = grid_rdata_i;
        mem_req_o.grid_re    = 1'b1;
        mem_req_o.grid_raddr = t2_q;
        state_d              = ST_LET2;
      end
      ST_LET2: begin
        if (out_free_i) begin
          res_o.load   = 1'b1;
          res_o.first  = letter_ascii(letter1_q);
          res_o.second = letter_ascii(grid_rdata_i);
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (start_pair) begin
      op_b_d              = pair_b;
      a_ok_d              = is_letter(pair_a) && pos_valid_ext[letter_of(pair_a)];
      held_valid_d        = 1'b0;
      mem_req_o.pos_re    = 1'b1;
      mem_req_o.pos_raddr = letter_of(pair_a);
      state_d             = ST_POS_B;
    end

    // Place a letter once, into the next free cell, while the grid has room.
    if (place_en && !pos_valid_ext[place_idx] && (cells_filled_q <= LastCell)) begin
      mem_req_o.grid_we    = 1'b1;
      mem_req_o.grid_waddr = cells_filled_q;
      mem_req_o.grid_wdata = place_idx;
      mem_req_o.pos_we     = 1'b1;
      mem_req_o.pos_waddr  = place_idx;
      mem_req_o.pos_wdata  = cells_filled_q;
      pos_valid_d[place_idx] = 1'b1;
      cells_filled_d       = cells_filled_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cells_filled_q <= '0;
      grid_ready_q   <= 1'b0;
      held_valid_q   <= 1'b0;
      prev_valid_q   <= 1'b0;
      pos_valid_q    <= '0;
      fill_idx_q     <= '0;
      a_ok_q         <= 1'b0;
      b_ok_q         <= 1'b0;
    end else begin
      state_q        <= state_d;
      cells_filled_q <= cells_filled_d;
      grid_ready_q   <= grid_ready_d;
      held_valid_q   <= held_valid_d;
      prev_valid_q   <= prev_valid_d;
      pos_valid_q    <= pos_valid_d;
      fill_idx_q     <= fill_idx_d;
      a_ok_q         <= a_ok_d;
      b_ok_q         <= b_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q    <= held_d;
    prev_q    <= prev_d;
    op_b_q    <= op_b_d;
    ca_q      <= ca_d;
    t2_q      <= t2_d;
    letter1_q <= letter1_d;
  end

endmodule

// File: rtl/core/playfair_digraph_encryptor_core.sv
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// input     in_valid_i / in_stall_o    req_type_i[1:0], char_byte_i[7:0]
// output    out_valid_o / out_stall_i  cipher_first_o[6:0], cipher_second_o[6:0]
//
// Key letters, unpaired text bytes and message ends without a held byte are
// taken without stalling the input. Key end walks the alphabet once through
// the placement logic. A completed digraph reads the position memory for each
// letter, then the grid memory for each cipher cell, on their single read ports.
// Reset clears all control state and the position valid bits; no clearing pass.
// A stalled output holds the last digraph stage until the output register frees.

module playfair_digraph_encryptor_core
  import pfde_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] char_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] cipher_first_o,
  output logic [6:0] cipher_second_o
);

  mem_req_t mem_req;
  res_t     res;
  letter_t  grid_rdata;
  cell_t    pos_rdata;
  logic     out_free;

  logic   out_valid_q;
  ascii_t first_q, second_q;

  // Sequencer: key placement, alphabet fill, digraph lookups.
  pfde_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .char_byte_i  (char_byte_i),
    .out_free_i   (out_free),
    .mem_req_o    (mem_req),
    .grid_rdata_i (grid_rdata),
    .pos_rdata_i  (pos_rdata),
    .res_o        (res)
  );

  // Grid memory: cell -> letter index.
  pfde_ram #(
    .Width (LetterW),
    .Depth (GridCells)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.grid_we),
    .waddr_i (mem_req.grid_waddr),
    .wdata_i (mem_req.grid_wdata),
    .re_i    (mem_req.grid_re),
    .raddr_i (mem_req.grid_raddr),
    .rdata_o (grid_rdata)
  );

  // Position memory: letter index -> cell; validity lives in the sequencer.
  pfde_ram #(
    .Width (CellW),
    .Depth (AlphaCount)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.pos_we),
    .waddr_i (mem_req.pos_waddr),
    .wdata_i (mem_req.pos_wdata),
    .re_i    (mem_req.pos_re),
    .raddr_i (mem_req.pos_raddr),
    .rdata_o (pos_rdata)
  );

  // Output register: free when empty or when the current transaction leaves.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the payload until a new digraph loads.
  always_ff @(posedge clk_i) begin
    if (res.load) begin
      first_q  <= res.first;
      second_q <= res.second;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cipher_first_o  = first_q;
  assign cipher_second_o = second_q;

endmodule

// File: rtl/core/pfde_chk.sv
`timescale 1ns / 1ps

module pfde_chk
  import pfde_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] req_type_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [6:0] cipher_first_o,
  input logic [6:0] cipher_second_o
);

  // A stalled transaction stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cipher_first_o)
      && $stable(cipher_second_o))
    else $error("stalled output transaction changed");

  // Cipher letters are lowercase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cipher_first_o >= 7'h61) && (cipher_first_o <= 7'h7a)
      && (cipher_second_o >= 7'h61) && (cipher_second_o <= 7'h7a))
    else $error("cipher letter out of range");

  // Reset empties the output register.
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

  // A new digraph only comes out of the lookup sequence, which stalls input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("digraph appeared without lookup sequence");

  // A key letter never starts a multi-cycle sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_KEY) |=> !in_stall_o)
    else $error("key letter stalled the input");

endmodule

bind playfair_digraph_encryptor_core pfde_chk u_pfde_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .req_type_i      (req_type_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .cipher_first_o  (cipher_first_o),
  .cipher_second_o (cipher_second_o)
);

// File: bench/tb_playfair_digraph_encryptor_core.sv
`timescale 1ns / 1ps

module tb_playfair_digraph_encryptor_core;
  import pfde_pkg::*;

  localparam int unsigned ItemTarget  = 1550;  // text and message-end transactions
  localparam int unsigned StallLimit  = 2000;  // cycles without any transaction
  localparam int unsigned HoldCycles  = 300;   // long receiver hold-off
  localparam int unsigned MaxWait     = 12;
  localparam int unsigned SettleCycles = 40;
  localparam byte_t       SkipByte    = 8'h6a;  // 'j'

  typedef struct {
    ascii_t first;
    ascii_t second;
  } digraph_t;

  // Keeps a private copy of the grid and the pairing state, and the queue of
  // digraphs the core still owes us.
  class digraph_scoreboard;
    letter_t     square [GridCells];
    bit          placed [AlphaCount];
    cell_t       spot   [AlphaCount];
    int unsigned filled;
    bit          ready;
    byte_t       held;
    bit          held_ok;
    byte_t       last_eff;
    bit          last_ok;
    digraph_t    owed [$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned digraphs;

    function new();
      foreach (square[i]) square[i] = '0;
      foreach (placed[i]) begin
        placed[i] = 1'b0;
        spot[i]   = '0;
      end
      filled     = 0;
      ready      = 1'b0;
      held       = '0;
      held_ok    = 1'b0;
      last_eff   = '0;
      last_ok    = 1'b0;
      mismatches = 0;
      requests   = 0;
      digraphs   = 0;
    endfunction

    function void place(int unsigned idx);
      if (filled >= GridCells || placed[idx]) return;
      square[filled] = letter_t'(idx);
      placed[idx]    = 1'b1;
      spot[idx]      = cell_t'(filled);
      filled++;
    endfunction

    // Anything off the grid lands on cell zero.
    function int unsigned locate(byte_t b);
      int unsigned idx;
      if (b < FirstByte || b > LastByte) return 0;
      idx = b - FirstByte;
      return placed[idx] ? int'(spot[idx]) : 0;
    endfunction

    function ascii_t glyph(int unsigned row, int unsigned col);
      return FirstAscii + ascii_t'(square[(row % GridSide) * GridSide + (col % GridSide)]);
    endfunction

    function void owe_pair(byte_t a, byte_t b);
      int unsigned ca, cb, r1, c1, r2, c2;
      digraph_t d;
      ca = locate(a);
      cb = locate(b);
      r1 = ca / GridSide;
      c1 = ca % GridSide;
      r2 = cb / GridSide;
      c2 = cb % GridSide;
      if (r1 == r2) begin
        // same row, also covers both letters on one cell
        d.first  = glyph(r1, c1 + 1);
        d.second = glyph(r2, c2 + 1);
      end else if (c1 == c2) begin
        d.first  = glyph(r1 + 1, c1);
        d.second = glyph(r2 + 1, c2);
      end else begin
        d.first  = glyph(r1, c2);
        d.second = glyph(r2, c1);
      end
      owed.insert(owed.size(), d);
    endfunction

    function void note_request(req_e kind, byte_t ch);
      byte_t eff;
      requests++;
      case (kind)
        REQ_KEY: begin
          if (!ready && ch >= FirstByte && ch <= LastByte) place(ch - FirstByte);
        end
        REQ_KEY_END: begin
          if (!ready) begin
            for (int unsigned l = 0; l < AlphaCount; l++) begin
              if (l != SkipLetter) place(l);
            end
            ready = 1'b1;
          end
        end
        REQ_TEXT: begin
          if (ready && ch != SpaceByte) begin
            eff      = (last_ok && ch == last_eff) ? PadByte : ch;
            last_eff = eff;
            last_ok  = 1'b1;
            if (!held_ok) begin
              held    = eff;
              held_ok = 1'b1;
            end else begin
              owe_pair(held, eff);
              held_ok = 1'b0;
            end
          end
        end
        default: begin
          if (ready) begin
            if (held_ok) owe_pair(held, PadByte);
            held_ok  = 1'b0;
            held     = '0;
            last_ok  = 1'b0;
            last_eff = '0;
          end
        end
      endcase
    endfunction

    function void check_digraph(ascii_t first, ascii_t second);
      digraph_t d;
      if (owed.size() == 0) begin
        $error("digraph %c%c arrived with nothing expected", first, second);
        mismatches++;
        return;
      end
      d = owed.pop_front();
      digraphs++;
      if (first !== d.first) begin
        $error("cipher_first: expected %c (%0d), got %c (%0d)",
               d.first, d.first, first, first);
        mismatches++;
      end
      if (second !== d.second) begin
        $error("cipher_second: expected %c (%0d), got %c (%0d)",
               d.second, d.second, second, second);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

  logic   clk_i;
  logic   rst_n      = 1'b0;
  logic   in_valid   = 1'b0;
  logic   in_stall_o;
  req_e   req_type   = REQ_KEY;
  byte_t  char_byte  = '0;
  logic   out_valid_o;
  logic   out_stall  = 1'b0;
  ascii_t cipher_first;
  ascii_t cipher_second;

  bit          idle_mode  = 1'b1;  // low: neither side inserts gaps
  bit          hold_req   = 1'b0;
  int unsigned sent_items = 0;

  digraph_scoreboard sb = new();

  playfair_digraph_encryptor_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type),
    .char_byte_i    (char_byte),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .cipher_first_o (cipher_first),
    .cipher_second_o(cipher_second)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hold reset at start, release on a falling edge, never assert again.
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;
  end

  function automatic int unsigned draw_wait();
    return idle_mode ? $urandom_range(0, MaxWait) : 0;
  endfunction

  // Mostly letters, with repeats to force the doubled-letter rule, spaces,
  // the pad and skip letters, and the odd raw byte.
  function automatic byte_t pick_text(byte_t prior);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70)      return byte_t'($urandom_range(FirstByte, LastByte));
    else if (roll < 80) return prior;
    else if (roll < 85) return SpaceByte;
    else if (roll < 90) return roll[0] ? PadByte : SkipByte;
    else                return byte_t'($urandom_range(0, 255));
  endfunction

  // Called on a falling edge; returns on the falling edge after the
  // transaction is taken, with valid still high.
  task automatic send(req_e kind, byte_t ch);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid  = 1'b1;
    req_type  = kind;
    char_byte = ch;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (kind == REQ_TEXT || kind == REQ_MSG_END) sent_items++;
  endtask

  // Drop valid and wait until the core has delivered every owed digraph.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Predict on every accepted input transaction, check every accepted result.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && !in_stall_o) sb.note_request(req_type, char_byte);
      if (out_valid_o && !out_stall) sb.check_digraph(cipher_first, cipher_second);
    end
  end

  // Receiver: stall each offered digraph for a drawn number of cycles; on
  // request, hold off for a long stretch so the core backs up.
  initial begin : receiver
    int unsigned wait_left;
    wait_left = draw_wait();
    @(posedge rst_n);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall) wait_left = draw_wait();
      else if (out_valid_o && wait_left > 0) wait_left--;
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_stall = (wait_left > 0);
    end
  end

  // End the run if no transaction moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("playfair_digraph_encryptor_core verification failed");
    $finish;
  end

  initial begin : stimulus
    byte_t       key_bytes [$];
    byte_t       deck [AlphaCount];
    byte_t       prior;
    byte_t       swap;
    byte_t       letter;
    req_e        noise_kind;
    int unsigned key_mode;
    int unsigned key_len;
    int unsigned pick;
    int unsigned msg_len;
    int unsigned msg_no;

    @(posedge rst_n);
    @(negedge clk_i);

    // Text and message end before any grid exists: both dropped.
    send(REQ_TEXT, 8'h61);
    send(REQ_MSG_END, 8'h00);

    // Key bytes outside a..z are ignored.
    send(REQ_KEY, 8'h00);
    send(REQ_KEY, 8'hff);
    send(REQ_KEY, 8'h41);
    send(REQ_KEY, SpaceByte);

    // One key per run since only reset rekeys: either overfill the grid,
    // use a short key holding 'j', or a short key without 'j'.
    key_mode = $urandom_range(0, 2);
    case (key_mode)
      0: begin
        foreach (deck[i]) deck[i] = FirstByte + byte_t'(i);
        for (int i = AlphaCount - 1; i > 0; i--) begin
          pick       = $urandom_range(0, i);
          swap       = deck[i];
          deck[i]    = deck[pick];
          deck[pick] = swap;
        end
        foreach (deck[i]) key_bytes.insert(key_bytes.size(), deck[i]);
        repeat (3) begin
          key_bytes.insert(key_bytes.size(),
                           byte_t'($urandom_range(FirstByte, LastByte)));
        end
      end
      1: begin
        key_len = $urandom_range(5, 15);
        repeat (key_len) begin
          key_bytes.insert(key_bytes.size(),
                           byte_t'($urandom_range(FirstByte, LastByte)));
        end
        key_bytes.insert($urandom_range(0, key_len), SkipByte);
      end
      default: begin
        key_len = $urandom_range(0, 10);
        repeat (key_len) begin
          do letter = byte_t'($urandom_range(FirstByte, LastByte));
          while (letter == SkipByte);
          key_bytes.insert(key_bytes.size(), letter);
        end
      end
    endcase
    foreach (key_bytes[i]) begin
      send(REQ_KEY, key_bytes[i]);
      if (i == 0) send(REQ_KEY, key_bytes[i]);  // repeated key letter
    end
    send(REQ_KEY_END, 8'h00);

    // Rekey attempts once the grid is ready: ignored.
    send(REQ_KEY, 8'h71);
    send(REQ_KEY_END, 8'h00);

    // "hello": the doubled l turns into x, the odd o gets padded.
    send(REQ_TEXT, 8'h68);
    send(REQ_TEXT, 8'h65);
    send(REQ_TEXT, 8'h6c);
    send(REQ_TEXT, 8'h6c);
    send(REQ_TEXT, 8'h6f);
    send(REQ_MSG_END, 8'h00);
    send(REQ_MSG_END, 8'hff);       // nothing held: no digraph
    send(REQ_TEXT, 8'h00);          // both off the grid: one cell
    send(REQ_TEXT, 8'hff);
    send(REQ_TEXT, 8'h62);
    send(REQ_TEXT, SpaceByte);      // dropped, b stays the previous byte
    send(REQ_TEXT, 8'h62);
    send(REQ_TEXT, SkipByte);
    send(REQ_TEXT, PadByte);
    send(REQ_TEXT, PadByte);
    send(REQ_TEXT, 8'h7f);
    send(REQ_TEXT, 8'h80);
    send(REQ_TEXT, LastByte);
    send(REQ_TEXT, FirstByte);
    send(REQ_MSG_END, 8'h00);

    // Random messages: mostly well-formed with random content, some left
    // unterminated, with stray key transactions mixed in.
    prior  = FirstByte;
    msg_no = 0;
    while (sent_items < ItemTarget) begin
      msg_no++;
      idle_mode = ($urandom_range(0, 3) != 0);
      if (msg_no == 8) begin
        // Stall the receiver and keep offering until the core pushes back.
        idle_mode = 1'b0;
        hold_req  = 1'b1;
        repeat (40) send(REQ_TEXT, byte_t'($urandom_range(FirstByte, LastByte)));
      end
      if (msg_no % 30 == 0) wait_drained();
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 16);
      repeat (msg_len) begin
        if ($urandom_range(0, 24) == 0) begin
          noise_kind = $urandom_range(0, 1) ? REQ_KEY : REQ_KEY_END;
          send(noise_kind, byte_t'($urandom_range(0, 255)));
        end
        prior = pick_text(prior);
        send(REQ_TEXT, prior);
      end
      if ($urandom_range(0, 9) != 0) send(REQ_MSG_END, byte_t'($urandom_range(0, 255)));
    end

    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);

    $display("Sent %0d transactions in %0d random messages, key style %0d.",
             sb.requests, msg_no, key_mode);
    $display("Checked %0d digraphs, %0d mismatches.", sb.digraphs, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("playfair_digraph_encryptor_core verification clean");
    end else begin
      $display("playfair_digraph_encryptor_core verification failed");
    end
    $finish;
  end

endmodule
